/* hw/rtl/rsep_pkg.sv */
package rsep_pkg;

	// largest number of source packets in one block
	localparam int unsigned MAX_DATA = 16;

	// configuration port geometry
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DATA_COUNT = 2'd0,
		CFG_PACKET_LEN = 2'd1,
		CFG_COEF_LOW   = 2'd2,
		CFG_COEF_HIGH  = 2'd3
	} cfg_idx_t;

	// block settings after range clamping
	typedef struct packed {
		logic [4:0]   k;
		logic [11:0]  len;
		logic [127:0] coef;
	} cfg_t;

	// multiply in GF(2^8), reduction polynomial 0x11D
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				r = r ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1D) : {x[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/rsep_if.sv */
// source byte channel
interface rsep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// parity byte channel
interface rsep_parity_if;
	logic       valid;
	logic       ready;
	logic [7:0] parity_byte;
	logic       last_byte;

	modport source (output valid, output parity_byte, output last_byte, input ready);
	modport sink (input valid, input parity_byte, input last_byte, output ready);
endinterface

/* hw/rtl/rsep_ram.sv */
module rsep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/rsep_cfg.sv */
module rsep_cfg import rsep_pkg::*; #(
	parameter int MAX_LEN = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [4:0]  data_count_q;
	logic [11:0] packet_len_q;
	logic [63:0] coef_low_q;
	logic [63:0] coef_high_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_count_q <= 5'd1;
			packet_len_q <= 12'd1;
			coef_low_q   <= '0;
			coef_high_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DATA_COUNT: data_count_q <= cfg_data[4:0];
				CFG_PACKET_LEN: packet_len_q <= cfg_data[11:0];
				CFG_COEF_LOW:   coef_low_q   <= cfg_data;
				CFG_COEF_HIGH:  coef_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp count and length into their usable ranges
	always_comb begin
		cfg.coef = {coef_high_q, coef_low_q};
		if (data_count_q == 5'd0) begin
			cfg.k = 5'd1;
		end else if (data_count_q > 5'(MAX_DATA)) begin
			cfg.k = 5'(MAX_DATA);
		end else begin
			cfg.k = data_count_q;
		end
		if (packet_len_q == 12'd0) begin
			cfg.len = 12'd1;
		end else if (32'(packet_len_q) > 32'(MAX_LEN)) begin
			cfg.len = 12'(MAX_LEN);
		end else begin
			cfg.len = packet_len_q;
		end
	end

endmodule

/* hw/rtl/rs_erasure_parity_encoder_top.sv */
// Reed-Solomon erasure parity encoder over GF(2^8). Source packets stream in one byte per
// item, packet 0 first; each byte is scaled by its packet's generator coefficient and folded
// into a per-position accumulator memory of MAX_LEN bytes. During the last packet every item
// yields one parity byte, with last_byte set on the packet's final position. The block takes
// one item per clock cycle, but a stalled output holds the whole pipeline. An item is
// registered in stage 1, which issues the accumulator read, then in stage 2, whose product
// is combined with the read data, and its result in the output register. The accumulator
// is not cleared: packet 0 overwrites every position, so no clearing pass follows reset.
// Configuration must be written between blocks, while no item is in flight; not enforced.
module rs_erasure_parity_encoder_top import rsep_pkg::*; #(
	parameter int MAX_LEN = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rsep_byte_if.sink             data_in,
	rsep_parity_if.source         parity_out
);

	localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CMPW  = (POS_W + 1 > 12) ? POS_W + 1 : 12;

	cfg_t cfg;

	logic [POS_W-1:0] byte_pos_q;
	logic [3:0]       pidx_q;

	logic             en;
	logic             acc;
	logic             last_pkt;
	logic             last_pos;
	logic [CMPW-1:0]  pos_inc;
	logic [7:0]       coef;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic [7:0]       coef_s1;
	logic [POS_W-1:0] pos_s1;
	logic             first_s1;
	logic             emit_s1;
	logic             lastpos_s1;

	logic             valid_s2;
	logic [7:0]       prod_s2;
	logic [POS_W-1:0] pos_s2;
	logic             first_s2;
	logic             emit_s2;
	logic             lastpos_s2;
	logic             fwd_s2;
	logic [7:0]       fwd_byte_s2;

	logic [7:0]       rdata;
	logic [7:0]       old_byte;
	logic [7:0]       val;

	logic             out_valid_q;
	logic [7:0]       parity_q;
	logic             last_q;

	rsep_cfg #(
		.MAX_LEN(MAX_LEN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// pipeline moves whenever the output register is free or being emptied
	assign en            = !out_valid_q || parity_out.ready;
	assign data_in.ready = en;
	assign acc           = data_in.valid && en;

	// position and packet bookkeeping for the arriving item
	assign pos_inc  = CMPW'(byte_pos_q) + CMPW'(1);
	assign last_pos = pos_inc >= CMPW'(cfg.len);
	assign last_pkt = ({1'b0, pidx_q} + 5'd1) >= cfg.k;
	assign coef     = cfg.coef[{pidx_q, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			pidx_q     <= '0;
		end else if (acc) begin
			if (last_pos) begin
				byte_pos_q <= '0;
				pidx_q     <= last_pkt ? 4'd0 : pidx_q + 4'd1;
			end else begin
				byte_pos_q <= pos_inc[POS_W-1:0];
			end
		end
	end

	// stage 1: captured item, accumulator read issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= data_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_s1    <= data_in.data_byte;
			coef_s1    <= coef;
			pos_s1     <= byte_pos_q;
			first_s1   <= pidx_q == 4'd0;
			emit_s1    <= last_pkt;
			lastpos_s1 <= last_pos;
		end
	end

	rsep_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LEN)
	) u_acc_ram (
		.clk  (clk),
		.we   (en && valid_s2),
		.waddr(pos_s2),
		.wdata(val),
		.re   (en && valid_s1),
		.raddr(pos_s1),
		.rdata(rdata)
	);

	// stage 2: product and forward of a write that lands on the same edge as the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2     <= gf_mul(coef_s1, data_s1);
			pos_s2      <= pos_s1;
			first_s2    <= first_s1;
			emit_s2     <= emit_s1;
			lastpos_s2  <= lastpos_s1;
			fwd_s2      <= valid_s2 && (pos_s2 == pos_s1);
			fwd_byte_s2 <= val;
		end
	end

	// combine with the stored partial sum; packet 0 starts a fresh sum
	assign old_byte = fwd_s2 ? fwd_byte_s2 : rdata;
	assign val      = first_s2 ? prod_s2 : (prod_s2 ^ old_byte);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			parity_q <= val;
			last_q   <= lastpos_s2;
		end
	end

	assign parity_out.valid       = out_valid_q;
	assign parity_out.parity_byte = parity_q;
	assign parity_out.last_byte   = last_q;

	// an accepted item always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted item missing from stage 1");

	// the final byte of the final packet restarts the block
	a_block_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_pos && last_pkt |=> byte_pos_q == '0 && pidx_q == 4'd0)
		else $error("block counters did not wrap");

	// a last-packet item leaving stage 2 becomes a result
	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 && emit_s2 |=> out_valid_q)
		else $error("parity result lost");

	// a held stage 1 item is not dropped while the output stalls
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en |=> valid_s1)
		else $error("stage 1 item dropped during stall");

endmodule
